@@ src/button_debounce_led_nkro_report_core_assert.svh @@
// Assertion macros used by the checker file of this block.
`ifndef BUTTON_DEBOUNCE_LED_NKRO_REPORT_CORE_ASSERT_SVH
`define BUTTON_DEBOUNCE_LED_NKRO_REPORT_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDNK_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BDNK_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bdnk_pkg.sv @@
package bdnk_pkg;

	localparam int NUM_BUTTONS  = 12;
	localparam int TIME_BITS    = 32;
	localparam int STAMP_W      = 32;
	localparam int DEBOUNCE_W   = 16;
	localparam int MODES_W      = 24;
	localparam int KEYS_W       = 42;
	localparam int KEY_W        = 7;
	localparam int KEYS_PER_REG = 6;
	localparam int REPORT_W     = 128;
	localparam int HALF_W       = 64;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 42;
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_W      = 1;
	localparam int Q_CNT_W      = 2;

	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(5);
	localparam logic [KEYS_W-1:0] KEYS_LOW_RST  = 42'd1177157095207;
	localparam logic [KEYS_W-1:0] KEYS_HIGH_RST = 42'd1592707863075;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE  = 3'd0,
		REG_LED_EN    = 3'd1,
		REG_LED_MODES = 3'd2,
		REG_KEYS_LOW  = 3'd3,
		REG_KEYS_HIGH = 3'd4
	} cfg_reg_t;

	// Modes 2 and 3 both mean off.
	typedef enum logic [1:0] {
		LED_PRESSED = 2'd0,
		LED_HOST    = 2'd1,
		LED_OFF     = 2'd2
	} led_mode_t;

	typedef struct packed {
		logic [DEBOUNCE_W-1:0] debounce_ms;
		logic                  led_enable;
		logic [MODES_W-1:0]    led_modes;
		logic [KEYS_W-1:0]     keycodes_low;
		logic [KEYS_W-1:0]     keycodes_high;
	} cfg_t;

	typedef struct packed {
		logic [NUM_BUTTONS-1:0] leds;
		logic [NUM_BUTTONS-1:0] pressed;
		logic                   host_ready;
	} q_entry_t;

	// Buttons past the register width read a mode of zero.
	function automatic logic [1:0] mode_of(input logic [MODES_W-1:0] modes, input int b);
		logic [MODES_W-1:0] s;
		s = modes >> (2 * b);
		return s[1:0];
	endfunction

	// Buttons past twelve have keycode zero.
	function automatic logic [KEY_W-1:0] key_of(input logic [KEYS_W-1:0] lo,
			input logic [KEYS_W-1:0] hi, input int b);
		logic [KEYS_W-1:0] s;
		if (b < KEYS_PER_REG) begin
			s = lo >> (KEY_W * b);
		end else if (b < 2 * KEYS_PER_REG) begin
			s = hi >> (KEY_W * (b - KEYS_PER_REG));
		end else begin
			s = '0;
		end
		return s[KEY_W-1:0];
	endfunction

endpackage

@@ src/bdnk_front.sv @@
module bdnk_front import bdnk_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [NUM_BUTTONS-1:0] pins_n,
	input  logic [STAMP_W-1:0]     now_ms,
	input  logic [NUM_BUTTONS-1:0] host_leds,
	input  logic                   host_ready,
	input  logic                   q_full,
	output logic                   push,
	output q_entry_t               push_data
);

	logic [NUM_BUTTONS-1:0] raw_q;
	logic [NUM_BUTTONS-1:0] press_q;
	logic [TIME_BITS-1:0]   ct_q [NUM_BUTTONS];

	logic [NUM_BUTTONS-1:0] cur;
	logic [NUM_BUTTONS-1:0] press_nxt;
	logic [NUM_BUTTONS-1:0] led_nxt;
	logic [TIME_BITS-1:0]   ct_nxt  [NUM_BUTTONS];
	logic [TIME_BITS-1:0]   elapsed [NUM_BUTTONS];
	logic [1:0]             mode    [NUM_BUTTONS];
	logic [TIME_BITS-1:0]   now_t;
	logic [TIME_BITS-1:0]   deb_t;

	assign in_stall = q_full;
	assign push     = in_valid & ~q_full;
	assign now_t    = now_ms[TIME_BITS-1:0];
	assign deb_t    = TIME_BITS'(cfg.debounce_ms);

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			cur[i]       = ~pins_n[NUM_BUTTONS-1-i];
			ct_nxt[i]    = (cur[i] != raw_q[i]) ? now_t : ct_q[i];
			elapsed[i]   = now_t - ct_nxt[i];
			press_nxt[i] = (elapsed[i] >= deb_t) ? cur[i] : press_q[i];
			mode[i]      = mode_of(cfg.led_modes, i);
			led_nxt[i]   = cfg.led_enable & (((mode[i] == LED_PRESSED) & press_nxt[i]) |
				((mode[i] == LED_HOST) & host_leds[i]));
		end
		push_data.leds       = led_nxt;
		push_data.pressed    = press_nxt;
		push_data.host_ready = host_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q   <= '0;
			press_q <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				ct_q[i] <= '0;
			end
		end else if (push) begin
			raw_q   <= cur;
			press_q <= press_nxt;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				ct_q[i] <= ct_nxt[i];
			end
		end
	end

endmodule

@@ src/bdnk_queue.sv @@
module bdnk_queue import bdnk_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t push_data,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output q_entry_t pop_data
);

	q_entry_t             ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	assign full     = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign valid    = (cnt_q != '0);
	assign pop_data = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ src/bdnk_back.sv @@
module bdnk_back import bdnk_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic                   q_valid,
	input  q_entry_t               q_data,
	output logic                   pop,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NUM_BUTTONS-1:0] leds,
	output logic [NUM_BUTTONS-1:0] pressed,
	output logic                   report_send,
	output logic [HALF_W-1:0]      report_low,
	output logic [HALF_W-1:0]      report_high
);

	logic [REPORT_W-1:0]    last_q;
	logic                   out_valid_q;
	logic [NUM_BUTTONS-1:0] leds_q;
	logic [NUM_BUTTONS-1:0] pressed_q;
	logic                   send_q;
	logic [REPORT_W-1:0]    rep_q;

	logic [REPORT_W-1:0]    rep;
	logic                   send;

	assign pop = q_valid & (~out_valid_q | ~out_stall);

	always_comb begin
		rep = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (q_data.pressed[i]) begin
				rep[key_of(cfg.keycodes_low, cfg.keycodes_high, i)] = 1'b1;
			end
		end
		send = q_data.host_ready & (rep != last_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			last_q      <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop && send) begin
				last_q <= rep;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			leds_q    <= q_data.leds;
			pressed_q <= q_data.pressed;
			send_q    <= send;
			rep_q     <= send ? rep : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign leds        = leds_q;
	assign pressed     = pressed_q;
	assign report_send = send_q;
	assign report_low  = rep_q[HALF_W-1:0];
	assign report_high = rep_q[REPORT_W-1:HALF_W];

endmodule

@@ src/button_debounce_led_nkro_report_core.sv @@
// Channel   Direction  Handshake            Payload
// input     in         in_valid/in_stall    pins_n, now_ms, host_leds, host_ready
// result    out        out_valid/out_stall  leds, pressed, report_send,
//                                           report_low, report_high
// config    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One transaction is accepted per cycle while in_stall is low, and each yields one result:
// the front updates the debounce lanes in the accepting cycle, then the result passes
// through the two-entry queue and the back's output register.
// Reset clears the debounce state, the queue, the output valid and the last report,
// and loads the register reset values; no clearing pass is needed.
// A stalled output holds its result; the queue takes two more transactions, then in_stall rises.
module button_debounce_led_nkro_report_core import bdnk_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [NUM_BUTTONS-1:0] pins_n,
	input  logic [STAMP_W-1:0]     now_ms,
	input  logic [NUM_BUTTONS-1:0] host_leds,
	input  logic                   host_ready,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NUM_BUTTONS-1:0] leds,
	output logic [NUM_BUTTONS-1:0] pressed,
	output logic                   report_send,
	output logic [HALF_W-1:0]      report_low,
	output logic [HALF_W-1:0]      report_high,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Configuration registers. Writes are always taken; an unknown index
	// changes nothing.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEBOUNCE_RST;
			cfg_q.led_enable    <= 1'b1;
			cfg_q.led_modes     <= '0;
			cfg_q.keycodes_low  <= KEYS_LOW_RST;
			cfg_q.keycodes_high <= KEYS_HIGH_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEBOUNCE:  cfg_q.debounce_ms   <= cfg_data[DEBOUNCE_W-1:0];
				REG_LED_EN:    cfg_q.led_enable    <= cfg_data[0];
				REG_LED_MODES: cfg_q.led_modes     <= cfg_data[MODES_W-1:0];
				REG_KEYS_LOW:  cfg_q.keycodes_low  <= cfg_data[KEYS_W-1:0];
				REG_KEYS_HIGH: cfg_q.keycodes_high <= cfg_data[KEYS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The front debounces and forms the LED and pressed vectors; the back builds the report
	// bitmap and filters unchanged reports and those made while host_ready is low.
	logic     q_push;
	logic     q_pop;
	logic     q_full;
	logic     q_valid;
	q_entry_t q_wdata;
	q_entry_t q_rdata;

	bdnk_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pins_n     (pins_n),
		.now_ms     (now_ms),
		.host_leds  (host_leds),
		.host_ready (host_ready),
		.q_full     (q_full),
		.push       (q_push),
		.push_data  (q_wdata)
	);

	bdnk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.valid     (q_valid),
		.pop_data  (q_rdata)
	);

	bdnk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_data      (q_rdata),
		.pop         (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.leds        (leds),
		.pressed     (pressed),
		.report_send (report_send),
		.report_low  (report_low),
		.report_high (report_high)
	);

endmodule

@@ src/bdnk_checker.sv @@
`include "button_debounce_led_nkro_report_core_assert.svh"

module bdnk_checker import bdnk_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [NUM_BUTTONS-1:0] pressed,
	input logic                   report_send,
	input logic [HALF_W-1:0]      report_low,
	input logic [HALF_W-1:0]      report_high
);

	`BDNK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(report_low) && $stable(report_high) && $stable(pressed),
		"stalled result changed")

	`BDNK_ASSERT_NOW(a_quiet_zero, clk, arst_n, out_valid && !report_send,
		report_low == '0 && report_high == '0, "unsent report is not zero")

	`BDNK_ASSERT_NOW(a_none_pressed, clk, arst_n, out_valid && report_send && pressed == '0,
		report_low == '0 && report_high == '0, "report bits with no button pressed")

	`BDNK_ASSERT_NOW(a_report_new, clk, arst_n,
		out_valid && report_send && $past(out_valid && !out_stall && report_send),
		report_low != $past(report_low) || report_high != $past(report_high),
		"repeated report was sent")

endmodule

bind button_debounce_led_nkro_report_core bdnk_checker u_bdnk_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pressed     (pressed),
	.report_send (report_send),
	.report_low  (report_low),
	.report_high (report_high)
);
